FILE: rtl/hsv_to_rgb_pixel_defines.svh
// assertion macros for the hsv to rgb pixel pipeline
// used by hsv_to_rgb_pixel, expects clk and rst in scope
`ifndef HSV_TO_RGB_PIXEL_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_DEFINES_SVH

// implication checked outside reset
`define H2R_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on every edge, reset included
`define H2R_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hsv2rgb_pkg.sv
// shared constants, sector codes, stage payload type and divide-by-255 helper
// no dependencies
package hsv2rgb_pkg;

  localparam int HUE_FRAC_BITS = 16;
  localparam int HUE_W = HUE_FRAC_BITS + 1;
  localparam int SCALE_W = HUE_FRAC_BITS + 8;

  localparam logic [HUE_FRAC_BITS:0] HUE_ONE = {1'b1, {HUE_FRAC_BITS{1'b0}}};
  localparam logic [SCALE_W-1:0] FULL_SCALE = {8'd255, {HUE_FRAC_BITS{1'b0}}};
  localparam logic [15:0] RECIP_255 = 16'd32897;

  localparam logic [2:0] SEC_RED     = 3'd0;
  localparam logic [2:0] SEC_YELLOW  = 3'd1;
  localparam logic [2:0] SEC_GREEN   = 3'd2;
  localparam logic [2:0] SEC_CYAN    = 3'd3;
  localparam logic [2:0] SEC_BLUE    = 3'd4;
  localparam logic [2:0] SEC_MAGENTA = 3'd5;

  typedef struct packed {
    logic [7:0]         v;
    logic [2:0]         sector;
    logic [7:0]         p;
    logic [SCALE_W-1:0] aq;
    logic [SCALE_W-1:0] at;
  } blend_t;

  // floor(m / 255), exact for any 16-bit m up to 65279, where the quotient fits 8 bits
  function automatic logic [7:0] div255(input logic [15:0] m);
    logic [31:0] prod;
    prod = 32'(m) * 32'(RECIP_255);
    return prod[30:23];
  endfunction

endpackage

FILE: rtl/hsv2rgb_front.sv
// first two pipeline stages: hue sector and fraction, p channel, q/t scale terms
// depends on hsv2rgb_pkg
module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               saturation,
  input  logic [7:0]               brightness,
  input  logic [HUE_FRAC_BITS-1:0] hue,
  output logic                     out_valid,
  input  logic                     out_ready,
  output blend_t                   out_data
);

  logic [HUE_FRAC_BITS+2:0] hue_x6;
  logic [15:0]              pm;

  logic                     s1_valid;
  logic                     s1_ready;
  logic [7:0]               s1_v;
  logic [7:0]               s1_sat;
  logic [2:0]               s1_sector;
  logic [HUE_FRAC_BITS-1:0] s1_f;
  logic [15:0]              s1_pm;

  logic                     s2_ready;
  logic [SCALE_W-1:0]       sat_f;
  logic [SCALE_W:0]         sat_nf;
  logic [SCALE_W:0]         at_full;
  blend_t                   s2_next;

  assign hue_x6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
  assign pm = 16'(brightness) * 16'(8'd255 - saturation);

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_v      <= brightness;
      s1_sat    <= saturation;
      s1_sector <= hue_x6[HUE_FRAC_BITS+2:HUE_FRAC_BITS];
      s1_f      <= hue_x6[HUE_FRAC_BITS-1:0];
      s1_pm     <= pm;
    end
  end

  // sat * f and sat * (one - f), subtracted from full scale
  assign sat_f   = SCALE_W'(s1_sat) * SCALE_W'(s1_f);
  assign sat_nf  = (SCALE_W+1)'(s1_sat) * (SCALE_W+1)'(HUE_ONE - {1'b0, s1_f});
  assign at_full = {1'b0, FULL_SCALE} - sat_nf;

  always_comb begin
    s2_next.v      = s1_v;
    s2_next.sector = s1_sector;
    s2_next.p      = div255(s1_pm);
    s2_next.aq     = FULL_SCALE - sat_f;
    s2_next.at     = at_full[SCALE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_data <= s2_next;
    end
  end

endmodule

FILE: rtl/hsv2rgb_scale.sv
// last two pipeline stages: scale q and t by value, divide, permute into rgb
// depends on hsv2rgb_pkg
module hsv2rgb_scale import hsv2rgb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  blend_t     in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic [SCALE_W+7:0] nq;
  logic [SCALE_W+7:0] nt;

  logic        s3_valid;
  logic        s3_ready;
  logic        s4_ready;
  logic [7:0]  s3_v;
  logic [7:0]  s3_p;
  logic [2:0]  s3_sector;
  logic [15:0] s3_mq;
  logic [15:0] s3_mt;

  logic [7:0]  q;
  logic [7:0]  t;
  logic [7:0]  red_next;
  logic [7:0]  green_next;
  logic [7:0]  blue_next;

  assign nq = (SCALE_W+8)'(in_data.v) * (SCALE_W+8)'(in_data.aq);
  assign nt = (SCALE_W+8)'(in_data.v) * (SCALE_W+8)'(in_data.at);

  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign in_ready = s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) begin
      s3_v      <= in_data.v;
      s3_p      <= in_data.p;
      s3_sector <= in_data.sector;
      s3_mq     <= nq[HUE_FRAC_BITS+15:HUE_FRAC_BITS];
      s3_mt     <= nt[HUE_FRAC_BITS+15:HUE_FRAC_BITS];
    end
  end

  assign q = div255(s3_mq);
  assign t = div255(s3_mt);

  always_comb begin
    case (s3_sector)
      SEC_YELLOW: begin
        red_next = q;    green_next = s3_v; blue_next = s3_p;
      end
      SEC_GREEN: begin
        red_next = s3_p; green_next = s3_v; blue_next = t;
      end
      SEC_CYAN: begin
        red_next = s3_p; green_next = q;    blue_next = s3_v;
      end
      SEC_BLUE: begin
        red_next = t;    green_next = s3_p; blue_next = s3_v;
      end
      SEC_MAGENTA: begin
        red_next = s3_v; green_next = s3_p; blue_next = q;
      end
      default: begin
        red_next = s3_v; green_next = t;    blue_next = s3_p;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s4_ready) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

FILE: rtl/hsv_to_rgb_pixel.sv
// Converts a stream of HSV pixels (saturation and value per pixel, hue from the
// cfg_data register in Q16, a full turn wrapping to zero) to 8-bit RGB. The
// pipeline has four register stages, and one request is taken every cycle while
// the output is not stalled; the depth is set by the two multiplier levels
// (saturation by hue fraction, then value by the scale term), the second followed
// by a reciprocal multiply for the divide by 255. Each stage stalls on its own,
// so bubbles close up and a stalled output does not block input while earlier
// stages have room.
// Write cfg_data only while no pixel is in flight.
// depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_scale, hsv_to_rgb_pixel_defines.svh
`include "hsv_to_rgb_pixel_defines.svh"

module hsv_to_rgb_pixel import hsv2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [HUE_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       saturation,
  input  logic [7:0]       brightness,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  logic [HUE_W-1:0] hue_fraction;
  logic             mid_valid;
  logic             mid_ready;
  blend_t           mid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_fraction <= '0;
    end else if (cfg_write) begin
      hue_fraction <= cfg_data;
    end
  end

  hsv2rgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .saturation (saturation),
    .brightness (brightness),
    .hue        (hue_fraction[HUE_FRAC_BITS-1:0]),
    .out_valid  (mid_valid),
    .out_ready  (mid_ready),
    .out_data   (mid_data)
  );

  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  `H2R_ASSERT(a_ready_when_drained, !out_valid, in_ready, "input stalled with empty output")
  `H2R_ASSERT(a_p_not_above_v, mid_valid, mid_data.p <= mid_data.v, "p channel exceeds value")
  `H2R_ASSERT(a_sector_range, mid_valid, mid_data.sector <= SEC_MAGENTA, "hue sector out of range")
  `H2R_ASSERT_ALWAYS(a_reset_flush, rst, ##1 (!out_valid && !mid_valid), "pipeline not flushed by reset")

endmodule

FILE: test/tb.sv
// self-checking testbench for hsv_to_rgb_pixel: hsv pixel requests under random idling
// a scoreboard class predicts rgb per request; depends on hsv2rgb_pkg and the rtl
module tb;
  import hsv2rgb_pkg::*;

  typedef struct packed {
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  class rgb_checker;
    logic [HUE_W-1:0] hue;
    pixel_t           pending_rgb[$];
    int unsigned      requests;
    int unsigned      results;
    int unsigned      mismatches;
    bit [5:0]         sectors_seen;

    function new();
      hue = '0;
      requests = 0;
      results = 0;
      mismatches = 0;
      sectors_seen = '0;
    endfunction

    function void set_hue(logic [HUE_W-1:0] h);
      hue = h;
    endfunction

    function void take_request(logic [7:0] sat, logic [7:0] val);
      longint unsigned one, full, h, x, f, s, v, p, q, t;
      logic [2:0] sector;
      pixel_t px;
      one = 64'd1 << HUE_FRAC_BITS;
      full = 255 * one;
      h = 64'(hue) % one;
      x = h * 6;
      sector = 3'(x >> HUE_FRAC_BITS);
      f = x % one;
      s = sat;
      v = val;
      p = v * (255 - s) / 255;
      q = v * (full - s * f) / full;
      t = v * (full - s * (one - f)) / full;
      px.sat = sat;
      px.val = val;
      case (sector)
        SEC_YELLOW:  {px.red, px.green, px.blue} = {8'(q), 8'(v), 8'(p)};
        SEC_GREEN:   {px.red, px.green, px.blue} = {8'(p), 8'(v), 8'(t)};
        SEC_CYAN:    {px.red, px.green, px.blue} = {8'(p), 8'(q), 8'(v)};
        SEC_BLUE:    {px.red, px.green, px.blue} = {8'(t), 8'(p), 8'(v)};
        SEC_MAGENTA: {px.red, px.green, px.blue} = {8'(v), 8'(p), 8'(q)};
        default: begin
          sector = SEC_RED;
          {px.red, px.green, px.blue} = {8'(v), 8'(t), 8'(p)};
        end
      endcase
      sectors_seen[sector] = 1'b1;
      requests++;
      pending_rgb.push_back(px);
    endfunction

    function void report(string chan, pixel_t px, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: hue %0d sat %0d val %0d expected %0d got %0d",
                 chan, hue, px.sat, px.val, want, got);
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_t want;
      results++;
      if (pending_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: pixel %0d %0d %0d with no request pending", r, g, b);
        return;
      end
      want = pending_rgb.pop_front();
      if (r !== want.red)   report("red", want, want.red, r);
      if (g !== want.green) report("green", want, want.green, g);
      if (b !== want.blue)  report("blue", want, want.blue, b);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [HUE_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       saturation = '0;
  logic [7:0]       brightness = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       red;
  logic [7:0]       green;
  logic [7:0]       blue;

  rgb_checker       board;
  logic             hold_req = 1'b0;
  logic             hold_seen = 1'b0;
  int unsigned      hold_left = 0;
  logic [15:0]      cyc = '0;
  int unsigned      hue_writes = 0;
  logic [HUE_W-1:0] hue_plan[$];

  hsv_to_rgb_pixel dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.take_request(saturation, brightness);
      if (out_valid && out_ready) board.check_pixel(red, green, blue);
    end
  end

  // output side: a long hold-off on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      cyc <= '0;
      hold_seen <= hold_req;
      hold_left <= 0;
    end else begin
      cyc <= cyc + 1'b1;
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= 60;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case (cyc[8:7])
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= ($urandom_range(0, 3) != 0);
          2'd2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= cyc[1] ^ cyc[3];
        endcase
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] s, input logic [7:0] b);
    in_valid <= 1'b1;
    saturation <= s;
    brightness <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending_rgb.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_hue(input logic [HUE_W-1:0] h);
    cfg_write <= 1'b1;
    cfg_data <= h;
    @(posedge clk);
    board.set_hue(h);
    hue_writes++;
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(input logic [HUE_W-1:0] h, input int n, input bit hold);
    int  burst;
    bit  steady;
    write_hue(h);
    steady = ($urandom_range(0, 3) == 0);
    burst = $urandom_range(1, 24);
    if (hold) hold_req <= ~hold_req;
    for (int i = 0; i < n; i++) begin
      send_pixel(pick_byte(), pick_byte());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (!steady) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
    drain();
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // grey, black, white and corner bytes at hue zero
    write_hue('0);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd1, 8'd128);
    send_pixel(8'd128, 8'd1);
    send_pixel(8'd170, 8'd85);
    send_pixel(8'd85, 8'd170);
    drain();
    // full turn wraps to zero
    write_hue(HUE_ONE);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd200, 8'd100);
    send_pixel(8'd0, 8'd77);
    drain();
    // largest register value, last sector just below the turn
    write_hue('1);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd255, 8'd128);
    send_pixel(8'd99, 8'd250);
    drain();
    // above one turn, integer part dropped
    write_hue(17'(HUE_ONE + 17'd10923));
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd128, 8'd255);
    drain();

    hue_plan = '{17'd1, 17'd65535, 17'd10922, 17'd10923, 17'd21845, 17'd21846,
                 17'd32768, 17'd43690, 17'd43691, 17'd54613, 17'd54614};
    hue_plan.push_back(17'(HUE_ONE + 17'($urandom_range(0, 65535))));
    repeat (3) hue_plan.push_back(17'($urandom_range(0, 131071)));
    foreach (hue_plan[i])
      random_phase(hue_plan[i], (i == 2) ? 90 : 45, i == 2);

    repeat (10) @(posedge clk);
    $display("%0d pixels converted over %0d hue settings, sectors reached %b, %0d mismatches",
             board.results, hue_writes, board.sectors_seen, board.mismatches);
    if (board.mismatches == 0 && board.pending_rgb.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
